### src/rrss_pkg.sv
// shared types and constants for the round-robin slice scheduler
// no dependencies
package rrss_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned ArrW   = 16;
  localparam int unsigned BurstW = 16;
  localparam int unsigned QuantW = 8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_NEXT  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  // one table entry as it sits in a cell
  typedef struct packed {
    logic              alive;
    logic [IdW-1:0]    id;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
  } entry_t;

  // per-cycle command from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic grant;
  } cell_cmd_t;

endpackage

### src/rrss_cell.sv
// one table slot: holds an entry, shifts right on insert, slices on grant
// depends on rrss_pkg
module rrss_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrss_pkg::cell_cmd_t  cmd_i,
  input  logic                 occupied_i,   // slot index below entry count
  input  logic                 sel_i,        // slot chosen by grant
  input  rrss_pkg::entry_t     new_i,        // record being loaded
  input  rrss_pkg::entry_t     left_i,       // neighbor's entry
  input  logic                 left_gt_i,    // neighbor arrival > new arrival
  input  logic [rrss_pkg::QuantW-1:0] quantum_i,
  output rrss_pkg::entry_t     entry_o,
  output logic                 gt_o          // this arrival > new arrival
);

  rrss_pkg::entry_t entry_d, entry_q;
  logic alive_d, alive_q;
  logic self_gt;

  assign self_gt = occupied_i && (entry_q.arrival > new_i.arrival);
  assign gt_o    = self_gt;

  always_comb begin
    entry_d = entry_q;
    alive_d = alive_q;
    if (cmd_i.clear) begin
      alive_d = 1'b0;
    end else if (cmd_i.insert) begin
      // positions of larger arrival shift right; first one takes the record
      if (left_gt_i) begin
        entry_d = left_i;
        alive_d = left_i.alive;
      end else if (self_gt || !occupied_i) begin
        entry_d = new_i;
        alive_d = 1'b1;
      end
    end else if (cmd_i.grant && sel_i) begin
      if (entry_q.burst > {{(rrss_pkg::BurstW-rrss_pkg::QuantW){1'b0}}, quantum_i}) begin
        entry_d.burst = entry_q.burst -
                        {{(rrss_pkg::BurstW-rrss_pkg::QuantW){1'b0}}, quantum_i};
      end else begin
        entry_d.burst = '0;
        alive_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else begin
      alive_q <= alive_d;
    end
  end

  always_comb begin
    entry_o       = entry_q;
    entry_o.alive = alive_q;
  end

endmodule

### src/round_robin_slice_scheduler_core.sv
// top level of the round-robin slice scheduler: sequencer plus a row of cells
// depends on rrss_pkg and rrss_cell
//
// The table is a row of MAX_PROCS cells kept in arrival order. A load inserts
// in parallel: every cell compares its arrival with the new one, cells with
// larger arrival shift one place right and the first of them takes the new
// record (a full table drops the load). A next request walks the row from
// the cursor one cell per cycle until an alive entry is found or every
// occupied cell has been tested; the walk over the cells sets the rate.
// After a grant a second walk-free summary (a nor of the alive bits of the
// occupied cells) gives schedule_done. The result sits in an output register
// until taken; no new beat is accepted while it waits. Loads and clears give
// no result beat.
module round_robin_slice_scheduler_core #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] process_id_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        slice_valid_o,
  output logic [15:0] granted_id_o,
  output logic [15:0] remaining_burst_o,
  output logic        finished_o,
  output logic        schedule_done_o
);

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);

  rrss_pkg::state_e state_q, state_d;

  logic [7:0]       quantum_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  cursor_q, cursor_d;
  logic [IdxW-1:0]  scan_q, scan_d;        // cell under test
  logic [CntW-1:0]  left_q, left_d;        // cells still to test
  logic             accept;
  logic             full;

  rrss_pkg::cell_cmd_t cmd;
  rrss_pkg::entry_t    new_entry;
  rrss_pkg::entry_t    ent [MAX_PROCS];
  logic [MAX_PROCS-1:0] gt, sel, occ, alive_vec;

  // output register
  logic        o_slice_q, o_fin_q, o_slice_d, o_fin_d;
  logic [15:0] o_id_q, o_rem_q, o_id_d, o_rem_d;
  logic        sched_done;
  logic        set_out, set_empty;

  assign full       = (count_q == CntW'(MAX_PROCS));
  assign in_stall_o = (state_q != rrss_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= 8'd4;
    end else if (cfg_we_i) begin
      quantum_q <= cfg_wdata_i;
    end
  end

  assign new_entry = '{alive: 1'b1, id: process_id_i, arrival: arrival_time_i,
                       burst: burst_time_i};

  // row of cells
  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    rrss_pkg::entry_t left_ent;
    logic             left_gt;
    assign occ[g]       = (CntW'(g) < count_q);
    assign sel[g]       = (scan_q == IdxW'(g));
    assign alive_vec[g] = ent[g].alive;
    if (g == 0) begin : g_first
      assign left_ent = new_entry;
      assign left_gt  = 1'b0;
    end else begin : g_rest
      assign left_ent = ent[g-1];
      assign left_gt  = gt[g-1];
    end
    rrss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .occupied_i (occ[g]),
      .sel_i      (sel[g]),
      .new_i      (new_entry),
      .left_i     (left_ent),
      .left_gt_i  (left_gt),
      .quantum_i  (quantum_q),
      .entry_o    (ent[g]),
      .gt_o       (gt[g])
    );
  end

  // entry under the scan pointer
  rrss_pkg::entry_t cur;
  logic             cur_hit;
  logic [15:0]      cur_rem;
  logic             cur_fin;
  logic [IdxW-1:0]  scan_nx;

  assign cur     = ent[scan_q];
  assign cur_hit = cur.alive && (CntW'(scan_q) < count_q);
  assign cur_fin = !(cur.burst > {8'd0, quantum_q});
  assign cur_rem = cur_fin ? 16'd0 : (cur.burst - {8'd0, quantum_q});
  assign scan_nx = (CntW'(scan_q) + CntW'(1) >= count_q) ? '0 : scan_q + IdxW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrss_pkg::ST_IDLE: begin
        if (accept && operation_i == rrss_pkg::OP_NEXT) begin
          state_d = (count_q == '0) ? rrss_pkg::ST_OUT : rrss_pkg::ST_SCAN;
        end
      end
      rrss_pkg::ST_SCAN: begin
        if (cur_hit || left_q == CntW'(1)) begin
          state_d = rrss_pkg::ST_OUT;
        end
      end
      rrss_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = rrss_pkg::ST_IDLE;
        end
      end
      default: state_d = rrss_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd       = '0;
    count_d   = count_q;
    cursor_d  = cursor_q;
    scan_d    = scan_q;
    left_d    = left_q;
    set_out   = 1'b0;
    set_empty = 1'b0;
    unique case (state_q)
      rrss_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (operation_i)
            rrss_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
              count_d   = '0;
              cursor_d  = '0;
            end
            rrss_pkg::OP_LOAD: begin
              if (!full) begin
                cmd.insert = 1'b1;
                count_d    = count_q + CntW'(1);
              end
            end
            rrss_pkg::OP_NEXT: begin
              scan_d    = (CntW'(cursor_q) < count_q) ? cursor_q : '0;
              left_d    = count_q;
              set_empty = (count_q == '0);
            end
            default: ;
          endcase
        end
      end
      rrss_pkg::ST_SCAN: begin
        if (cur_hit) begin
          cmd.grant = 1'b1;
          set_out   = 1'b1;
          cursor_d  = scan_nx;
        end else if (left_q == CntW'(1)) begin
          set_empty = 1'b1;
        end else begin
          scan_d = scan_nx;
          left_d = left_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    o_slice_d = o_slice_q;
    o_fin_d   = o_fin_q;
    o_id_d    = o_id_q;
    o_rem_d   = o_rem_q;
    if (set_out) begin
      o_slice_d = 1'b1;
      o_fin_d   = cur_fin;
      o_id_d    = cur.id;
      o_rem_d   = cur_rem;
    end else if (set_empty) begin
      o_slice_d = 1'b0;
      o_fin_d   = 1'b0;
      o_id_d    = '0;
      o_rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rrss_pkg::ST_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      scan_q   <= '0;
      left_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      scan_q   <= scan_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_slice_q <= o_slice_d;
    o_fin_q   <= o_fin_d;
    o_id_q    <= o_id_d;
    o_rem_q   <= o_rem_d;
  end

  // done is read from the cells once the grant has landed
  assign sched_done        = ~|(alive_vec & occ);
  assign out_valid_o       = (state_q == rrss_pkg::ST_OUT);
  assign slice_valid_o     = o_slice_q;
  assign granted_id_o      = o_id_q;
  assign remaining_burst_o = o_rem_q;
  assign finished_o        = o_fin_q;
  assign schedule_done_o   = sched_done;

  // assertions
  a_count_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PROCS)) else $error("entry count overflow");
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> remaining_burst_o == '0)
    else $error("finished slice with burst left");
  a_empty_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !slice_valid_o) |-> schedule_done_o)
    else $error("no slice but not done");

endmodule

### bench/testbench.sv
// self-checking bench for round_robin_slice_scheduler_core
// depends on rrss_pkg and the scheduler rtl; clocked driver and monitor,
// an in-bench slice predictor and a queue of expected slices
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Procs   = 16;
  // a next request may walk the whole row plus output register
  localparam int unsigned DrainCy = 2 * Procs + 8;

  typedef struct {
    rrss_pkg::op_e                     op;
    logic [rrss_pkg::IdW-1:0]    pid;
    logic [rrss_pkg::ArrW-1:0]   arr;
    logic [rrss_pkg::BurstW-1:0] burst;
  } sched_cmd_t;

  typedef struct {
    logic                        granted;
    logic [rrss_pkg::IdW-1:0]    gid;
    logic [rrss_pkg::BurstW-1:0] left;
    logic                        fin;
    logic                        done;
  } slice_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = rrss_pkg::OP_NONE;
  logic [15:0] process_id_i = '0, arrival_time_i = '0, burst_time_i = '0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic slice_valid_o, finished_o, schedule_done_o;
  logic [15:0] granted_id_o, remaining_burst_o;

  sched_cmd_t cmd_fifo[$];
  slice_t     slices_due[$];
  int         errors = 0;
  logic       took = 1'b0;
  logic       calm = 1'b0;    // no idling on either side
  logic       hold = 1'b0;    // long receiver hold-off
  logic       pressure_done = 1'b0;

  // predictor copy of the process table
  logic [rrss_pkg::IdW-1:0]  tab_id[Procs];
  logic [rrss_pkg::ArrW-1:0] tab_arr[Procs];
  int unsigned               tab_burst[Procs];
  logic                      tab_alive[Procs];
  int unsigned               tab_cnt = 0;
  int unsigned               cursor = 0;
  int unsigned               quantum = 4;

  always #1 clk_i = ~clk_i;

  round_robin_slice_scheduler_core #(.MAX_PROCS(Procs)) DUT (.*);

  task automatic report_miss(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // apply one accepted beat to the table, queue a slice for next requests
  task automatic apply_cmd(sched_cmd_t c);
    int unsigned pos, idx, start;
    slice_t s;
    bit hit;
    s = '{1'b0, '0, '0, 1'b0, 1'b1};
    hit = 0;
    idx = 0;
    case (c.op)
      rrss_pkg::OP_CLEAR: begin
        for (int j = 0; j < Procs; j++) tab_alive[j] = 1'b0;
        tab_cnt = 0;
        cursor = 0;
      end
      rrss_pkg::OP_LOAD: begin
        // stable insert after every entry with arrival not above the new one
        if (tab_cnt < Procs) begin
          pos = tab_cnt;
          while (pos > 0 && tab_arr[pos-1] > c.arr) pos--;
          for (int k = tab_cnt; k > pos; k--) begin
            tab_id[k] = tab_id[k-1];
            tab_arr[k] = tab_arr[k-1];
            tab_burst[k] = tab_burst[k-1];
            tab_alive[k] = tab_alive[k-1];
          end
          tab_id[pos] = c.pid;
          tab_arr[pos] = c.arr;
          tab_burst[pos] = c.burst;
          tab_alive[pos] = 1'b1;
          tab_cnt++;
        end
      end
      rrss_pkg::OP_NEXT: begin
        if (tab_cnt != 0) begin
          start = (cursor < tab_cnt) ? cursor : 0;
          for (int k = 0; k < tab_cnt && !hit; k++) begin
            idx = (start + k) % tab_cnt;
            hit = tab_alive[idx];
          end
        end
        if (hit) begin
          if (tab_burst[idx] > quantum) begin
            tab_burst[idx] -= quantum;
          end else begin
            tab_burst[idx] = 0;
            tab_alive[idx] = 1'b0;
            s.fin = 1'b1;
          end
          cursor = (idx + 1 >= tab_cnt) ? 0 : idx + 1;
          s.granted = 1'b1;
          s.gid = tab_id[idx];
          s.left = tab_burst[idx][15:0];
          s.done = 1'b1;
          for (int k = 0; k < tab_cnt; k++) if (tab_alive[k]) s.done = 1'b0;
        end
        slices_due.push_back(s);
      end
      default: ;  // unused operation is ignored
    endcase
  endtask

  // input side: accept detection at the rising edge, new beat at the falling edge
  always @(posedge clk_i) begin
    took <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      apply_cmd('{rrss_pkg::op_e'(operation_i), process_id_i, arrival_time_i,
                  burst_time_i});
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took)) begin
      if (cmd_fifo.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
        sched_cmd_t c;
        c = cmd_fifo.pop_front();
        operation_i <= c.op;
        process_id_i <= c.pid;
        arrival_time_i <= c.arr;
        burst_time_i <= c.burst;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk_i)
    out_stall_i <= hold || (!calm && $urandom_range(99) < 37);

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (slices_due.size() == 0) begin
        $display("unexpected slice beat at %0t", $realtime);
        errors++;
      end else begin
        slice_t w;
        w = slices_due.pop_front();
        if (slice_valid_o !== w.granted) report_miss("slice_valid", slice_valid_o, w.granted);
        if (granted_id_o !== w.gid) report_miss("granted_id", granted_id_o, w.gid);
        if (remaining_burst_o !== w.left)
          report_miss("remaining_burst", remaining_burst_o, w.left);
        if (finished_o !== w.fin) report_miss("finished", finished_o, w.fin);
        if (schedule_done_o !== w.done)
          report_miss("schedule_done", schedule_done_o, w.done);
      end
    end
  end

  function automatic sched_cmd_t mk(rrss_pkg::op_e op, int unsigned p = 0,
                                    int unsigned a = 0, int unsigned b = 0);
    mk = '{op, p[15:0], a[15:0], b[15:0]};
  endfunction

  // random load: mostly small bursts and close arrivals so ties happen
  function automatic sched_cmd_t rand_load();
    rand_load = mk(rrss_pkg::OP_LOAD, $urandom_range(16'hFFFF),
                   ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(12),
                   ($urandom_range(7) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(40));
  endfunction

  // wait until the block is idle, then write the quantum
  task automatic set_quantum(int unsigned q);
    while (cmd_fifo.size() != 0 || in_valid_i || slices_due.size() != 0) @(posedge clk_i);
    repeat (DrainCy) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= q[7:0];
    quantum = q;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one random schedule: clear, a batch of loads, then mostly next requests
  task automatic rand_schedule();
    int unsigned n;
    cmd_fifo.push_back(mk(rrss_pkg::OP_CLEAR));
    n = $urandom_range(1, 18);   // sometimes overfills the table
    repeat (n) cmd_fifo.push_back(rand_load());
    repeat ($urandom_range(4, 30)) begin
      case ($urandom_range(19))
        0: cmd_fifo.push_back(rand_load());         // load during a schedule
        1: cmd_fifo.push_back(mk(rrss_pkg::OP_NONE, $urandom_range(16'hFFFF)));
        2: cmd_fifo.push_back(mk(rrss_pkg::op_e'($urandom_range(3)),
                                 $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                                 $urandom_range(16'hFFFF)));
        default: cmd_fifo.push_back(mk(rrss_pkg::OP_NEXT));
      endcase
    end
  endtask

  initial begin
    int unsigned issued;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, ties, overflow, unused op, clear
    cmd_fifo.push_back(mk(rrss_pkg::OP_NEXT));
    cmd_fifo.push_back(mk(rrss_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    cmd_fifo.push_back(mk(rrss_pkg::OP_LOAD, 0, 0, 0));         // zero burst still gets a slice
    cmd_fifo.push_back(mk(rrss_pkg::OP_LOAD, 16'h1234, 5, 4));  // burst equal to quantum
    cmd_fifo.push_back(mk(rrss_pkg::OP_LOAD, 16'h1235, 5, 5));  // tie keeps load order
    cmd_fifo.push_back(mk(rrss_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (6) cmd_fifo.push_back(mk(rrss_pkg::OP_NEXT));
    cmd_fifo.push_back(mk(rrss_pkg::OP_CLEAR));
    cmd_fifo.push_back(mk(rrss_pkg::OP_NEXT));
    for (int i = 0; i < 17; i++)
      cmd_fifo.push_back(mk(rrss_pkg::OP_LOAD, i, 16 - i, 1));  // full, then drop
    repeat (18) cmd_fifo.push_back(mk(rrss_pkg::OP_NEXT));
    issued = 50;

    set_quantum(1);
    repeat (4) begin
      rand_schedule();
      issued += 30;
    end
    set_quantum(255);
    repeat (4) begin
      rand_schedule();
      issued += 30;
    end
    set_quantum(4);
    while (issued < 560) begin
      rand_schedule();
      issued += 30;
      if ($urandom_range(5) == 0) set_quantum($urandom_range(1, 255));
    end

    while (!pressure_done || cmd_fifo.size() != 0 || in_valid_i || slices_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCy) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // a quiet stretch, then a long receiver hold-off while items keep coming
  initial begin
    repeat (300) @(posedge clk_i);
    calm = 1'b1;
    repeat (600) @(posedge clk_i);
    calm = 1'b0;
    while (cmd_fifo.size() < 8) @(posedge clk_i);
    hold = 1'b1;
    repeat (300) @(posedge clk_i);
    hold = 1'b0;
    pressure_done = 1'b1;
  end

  initial begin
    #500us;
    $display("testbench failed");
    $finish;
  end

endmodule

### filelist.f
src/rrss_pkg.sv
src/rrss_cell.sv
src/round_robin_slice_scheduler_core.sv
bench/testbench.sv
